>>> rtl/exvr_pkg.sv
// shared types and constants for the euler xyz vertex rotator
package exvr_pkg;

    localparam int REG_BITS      = 18;
    localparam int COORD_BITS    = 32;
    localparam int CFG_ADDR_BITS = 3;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_COS_X = 3'd0,
        REG_SIN_X = 3'd1,
        REG_COS_Y = 3'd2,
        REG_SIN_Y = 3'd3,
        REG_COS_Z = 3'd4,
        REG_SIN_Z = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic mul;
        logic sum;
    } stage_en_t;

endpackage

>>> rtl/euler_xyz_vertex_rotate.sv
// top level of the euler xyz vertex rotator
// Rotates one vertex per clock about x, then y, then z, using cosine and sine
// values written as Q2.16 into six registers. A vertex enters on every cycle in
// which the output side keeps up; its result is offered on the output after the
// multiply stage and the shift, combine and saturate stage of each of the three
// plane rotations. Each stage stalls only when the stage after it is full and
// stalled, so bubbles are squeezed out and the input keeps taking transactions
// while a finished result waits at the output, until every stage is full. The
// registers should be written only while no vertex is in flight.
module euler_xyz_vertex_rotate #(
    parameter int FRAC_BITS  = 16,
    parameter int INDEX_BITS = 16,
    localparam int DATA_BITS = ((INDEX_BITS + 3 * exvr_pkg::COORD_BITS + 7) / 8) * 8,
    localparam int COEF_BITS = (FRAC_BITS + 2 > exvr_pkg::REG_BITS) ?
                               FRAC_BITS + 2 : exvr_pkg::REG_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [exvr_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [COEF_BITS-1:0]                  cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // vertex_index, x_in, y_in, z_in, zero fill
    input  logic [DATA_BITS-1:0]                  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // vertex_index_out, x_out, y_out, z_out, zero fill
    output logic [DATA_BITS-1:0]                  m_axis_tdata
);

    localparam int CB        = exvr_pkg::COORD_BITS;
    localparam int PASS_BITS = INDEX_BITS + CB;
    localparam int STAGES    = 6;
    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << FRAC_BITS;
    localparam logic signed [COEF_BITS-1:0] COEF_ZERO = '0;

    logic signed [COEF_BITS-1:0] cos_x_reg;
    logic signed [COEF_BITS-1:0] sin_x_reg;
    logic signed [COEF_BITS-1:0] cos_y_reg;
    logic signed [COEF_BITS-1:0] sin_y_reg;
    logic signed [COEF_BITS-1:0] cos_z_reg;
    logic signed [COEF_BITS-1:0] sin_z_reg;
    logic signed [COEF_BITS-1:0] coef_wdata;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   ready_stage;

    exvr_pkg::stage_en_t en_x;
    exvr_pkg::stage_en_t en_y;
    exvr_pkg::stage_en_t en_z;

    logic [INDEX_BITS-1:0]      idx_in;
    logic signed [CB-1:0]       x_in;
    logic signed [CB-1:0]       y_in;
    logic signed [CB-1:0]       z_in;

    logic signed [CB-1:0]       y1;
    logic signed [CB-1:0]       z1;
    logic signed [CB-1:0]       x2;
    logic signed [CB-1:0]       z2;
    logic signed [CB-1:0]       x3;
    logic signed [CB-1:0]       y3;
    logic [PASS_BITS-1:0]       pass_x;
    logic [PASS_BITS-1:0]       pass_y;
    logic [PASS_BITS-1:0]       pass_z;

    // configuration registers
    assign coef_wdata = cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_x_reg <= COEF_ONE;
            sin_x_reg <= COEF_ZERO;
            cos_y_reg <= COEF_ONE;
            sin_y_reg <= COEF_ZERO;
            cos_z_reg <= COEF_ONE;
            sin_z_reg <= COEF_ZERO;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                exvr_pkg::REG_COS_X: cos_x_reg <= coef_wdata;
                exvr_pkg::REG_SIN_X: sin_x_reg <= coef_wdata;
                exvr_pkg::REG_COS_Y: cos_y_reg <= coef_wdata;
                exvr_pkg::REG_SIN_Y: sin_y_reg <= coef_wdata;
                exvr_pkg::REG_COS_Z: cos_z_reg <= coef_wdata;
                exvr_pkg::REG_SIN_Z: sin_z_reg <= coef_wdata;
                default: ;
            endcase
        end
    end

    // per-stage flow control
    always_comb
    begin
        ready_stage[STAGES] = m_axis_tready;
        for (int i = STAGES - 1; i >= 0; i--)
            ready_stage[i] = !valid_reg[i] || ready_stage[i+1];
    end

    assign valid_next = {valid_reg[STAGES-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (ready_stage[i])
                    valid_reg[i] <= valid_next[i];
            end
        end
    end

    assign en_x = '{mul: ready_stage[0], sum: ready_stage[1]};
    assign en_y = '{mul: ready_stage[2], sum: ready_stage[3]};
    assign en_z = '{mul: ready_stage[4], sum: ready_stage[5]};

    assign idx_in = s_axis_tdata[INDEX_BITS-1:0];
    assign x_in   = s_axis_tdata[INDEX_BITS +: CB];
    assign y_in   = s_axis_tdata[INDEX_BITS + CB +: CB];
    assign z_in   = s_axis_tdata[INDEX_BITS + 2 * CB +: CB];

    // y-z plane by the x angle
    exvr_plane_rot #(
        .FRAC_BITS (FRAC_BITS),
        .COEF_BITS (COEF_BITS),
        .PASS_BITS (PASS_BITS)
    ) u_rot_x (
        .clk        (clk),
        .en         (en_x),
        .a          (y_in),
        .b          (z_in),
        .c          (cos_x_reg),
        .s          (sin_x_reg),
        .pass_in    ({x_in, idx_in}),
        .first_out  (y1),
        .second_out (z1),
        .pass_out   (pass_x)
    );

    // x-z plane by the y angle
    exvr_plane_rot #(
        .FRAC_BITS (FRAC_BITS),
        .COEF_BITS (COEF_BITS),
        .PASS_BITS (PASS_BITS)
    ) u_rot_y (
        .clk        (clk),
        .en         (en_y),
        .a          (pass_x[INDEX_BITS +: CB]),
        .b          (z1),
        .c          (cos_y_reg),
        .s          (sin_y_reg),
        .pass_in    ({y1, pass_x[INDEX_BITS-1:0]}),
        .first_out  (x2),
        .second_out (z2),
        .pass_out   (pass_y)
    );

    // x-y plane by the z angle
    exvr_plane_rot #(
        .FRAC_BITS (FRAC_BITS),
        .COEF_BITS (COEF_BITS),
        .PASS_BITS (PASS_BITS)
    ) u_rot_z (
        .clk        (clk),
        .en         (en_z),
        .a          (x2),
        .b          (pass_y[INDEX_BITS +: CB]),
        .c          (cos_z_reg),
        .s          (sin_z_reg),
        .pass_in    ({z2, pass_y[INDEX_BITS-1:0]}),
        .first_out  (x3),
        .second_out (y3),
        .pass_out   (pass_z)
    );

    assign s_axis_tready = ready_stage[0];
    assign m_axis_tvalid = valid_reg[STAGES-1];
    assign m_axis_tdata  = DATA_BITS'({pass_z[INDEX_BITS +: CB], y3, x3,
                                      pass_z[INDEX_BITS-1:0]});

endmodule

>>> rtl/exvr_plane_rot.sv
// one plane rotation: multiply stage, then shift, combine and saturate stage
module exvr_plane_rot #(
    parameter int FRAC_BITS = 16,
    parameter int COEF_BITS = 18,
    parameter int PASS_BITS = 48
) (
    input  logic                                   clk,
    input  exvr_pkg::stage_en_t                    en,
    input  logic signed [exvr_pkg::COORD_BITS-1:0] a,
    input  logic signed [exvr_pkg::COORD_BITS-1:0] b,
    input  logic signed [COEF_BITS-1:0]            c,
    input  logic signed [COEF_BITS-1:0]            s,
    input  logic        [PASS_BITS-1:0]            pass_in,
    output logic signed [exvr_pkg::COORD_BITS-1:0] first_out,
    output logic signed [exvr_pkg::COORD_BITS-1:0] second_out,
    output logic        [PASS_BITS-1:0]            pass_out
);

    localparam int PROD_BITS = exvr_pkg::COORD_BITS + COEF_BITS;
    localparam logic signed [PROD_BITS-1:0] MAX_EXT = PROD_BITS'(exvr_pkg::COORD_MAX);
    localparam logic signed [PROD_BITS-1:0] MIN_EXT = PROD_BITS'(exvr_pkg::COORD_MIN);

    logic signed [PROD_BITS-1:0] a_ext;
    logic signed [PROD_BITS-1:0] b_ext;
    logic signed [PROD_BITS-1:0] c_ext;
    logic signed [PROD_BITS-1:0] s_ext;

    logic signed [PROD_BITS-1:0] ac_reg;
    logic signed [PROD_BITS-1:0] bs_reg;
    logic signed [PROD_BITS-1:0] as_reg;
    logic signed [PROD_BITS-1:0] bc_reg;
    logic        [PASS_BITS-1:0] pass_mid_reg;

    logic signed [PROD_BITS-1:0] diff;
    logic signed [PROD_BITS-1:0] total;
    logic signed [exvr_pkg::COORD_BITS-1:0] first_next;
    logic signed [exvr_pkg::COORD_BITS-1:0] second_next;

    logic signed [exvr_pkg::COORD_BITS-1:0] first_reg;
    logic signed [exvr_pkg::COORD_BITS-1:0] second_reg;
    logic        [PASS_BITS-1:0]            pass_reg;

    assign a_ext = PROD_BITS'(a);
    assign b_ext = PROD_BITS'(b);
    assign c_ext = PROD_BITS'(c);
    assign s_ext = PROD_BITS'(s);

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            ac_reg       <= a_ext * c_ext;
            bs_reg       <= b_ext * s_ext;
            as_reg       <= a_ext * s_ext;
            bc_reg       <= b_ext * c_ext;
            pass_mid_reg <= pass_in;
        end
    end

    // each product truncated on its own toward minus infinity
    always_comb
    begin
        diff  = (ac_reg >>> FRAC_BITS) - (bs_reg >>> FRAC_BITS);
        total = (as_reg >>> FRAC_BITS) + (bc_reg >>> FRAC_BITS);

        if (diff > MAX_EXT)
            first_next = exvr_pkg::COORD_MAX;
        else if (diff < MIN_EXT)
            first_next = exvr_pkg::COORD_MIN;
        else
            first_next = diff[exvr_pkg::COORD_BITS-1:0];

        if (total > MAX_EXT)
            second_next = exvr_pkg::COORD_MAX;
        else if (total < MIN_EXT)
            second_next = exvr_pkg::COORD_MIN;
        else
            second_next = total[exvr_pkg::COORD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            pass_reg   <= pass_mid_reg;
        end
    end

    assign first_out  = first_reg;
    assign second_out = second_reg;
    assign pass_out   = pass_reg;

endmodule

>>> rtl/exvr_checker.sv
// port-level checks for the euler xyz vertex rotator, bound to the top level
module exvr_checker #(
    parameter int DATA_BITS = 112
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [DATA_BITS-1:0] m_axis_tdata
);

    // stalled output holds its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // input is refused only when the whole pipeline is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused with room in the pipeline");

    // with the output ready throughout, an accepted transaction reaches the output once it has passed every stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind euler_xyz_vertex_rotate exvr_checker #(
    .DATA_BITS (DATA_BITS)
) u_exvr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
